// File: sv/c2pq_pkg.sv
// ============================================================================
// c2pq_pkg: shared types and constants for the cartesian-to-polar converter
// Location codes, angle constants, CORDIC arctangent steps, default sizes.
// ============================================================================
package c2pq_pkg;

    // default sizes
    localparam int COORD_BITS_DEFAULT    = 16;
    localparam int CORDIC_STAGES_DEFAULT = 16;

    // CORDIC datapath formats
    localparam int CORDIC_GUARD   = 24;   // fraction bits below the coordinate LSB
    localparam int ATAN_TABLE_LEN = 24;   // longest useful iteration count
    localparam int ZW             = 32;   // angle accumulator, 2^-32 turn units

    // result formats
    localparam int MAG_BITS   = 16;
    localparam int ANGLE_BITS = 16;
    localparam int LOC_BITS   = 3;

    // location class codes
    localparam logic [LOC_BITS-1:0] LOC_ORIGIN = 3'd0;
    localparam logic [LOC_BITS-1:0] LOC_Y_AXIS = 3'd1;
    localparam logic [LOC_BITS-1:0] LOC_X_AXIS = 3'd2;
    localparam logic [LOC_BITS-1:0] LOC_Q1     = 3'd3;
    localparam logic [LOC_BITS-1:0] LOC_Q2     = 3'd4;
    localparam logic [LOC_BITS-1:0] LOC_Q3     = 3'd5;
    localparam logic [LOC_BITS-1:0] LOC_Q4     = 3'd6;

    // angles in 1/65536 turn
    localparam logic [ANGLE_BITS-1:0] ANGLE_0   = 16'd0;
    localparam logic [ANGLE_BITS-1:0] ANGLE_90  = 16'd16384;
    localparam logic [ANGLE_BITS-1:0] ANGLE_180 = 16'd32768;
    localparam logic [ANGLE_BITS-1:0] ANGLE_270 = 16'd49152;

    localparam logic [MAG_BITS-1:0] MAG_MAX = 16'hFFFF;

    // class that rides along with every item
    typedef struct packed {
        logic [LOC_BITS-1:0] location;
        logic                neg;       // sign of the nonzero coordinate on an axis
    } tag_t;

    // atan(2^-i) / (2*pi) * 2^32, rounded
    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0:       val = 32'sd536870912;
            1:       val = 32'sd316933406;
            2:       val = 32'sd167458907;
            3:       val = 32'sd85004756;
            4:       val = 32'sd42667331;
            5:       val = 32'sd21354465;
            6:       val = 32'sd10679838;
            7:       val = 32'sd5340245;
            8:       val = 32'sd2670163;
            9:       val = 32'sd1335087;
            10:      val = 32'sd667544;
            11:      val = 32'sd333772;
            12:      val = 32'sd166886;
            13:      val = 32'sd83443;
            14:      val = 32'sd41722;
            15:      val = 32'sd20861;
            16:      val = 32'sd10430;
            17:      val = 32'sd5215;
            18:      val = 32'sd2608;
            19:      val = 32'sd1304;
            20:      val = 32'sd652;
            21:      val = 32'sd326;
            22:      val = 32'sd163;
            23:      val = 32'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: sv/cartesian_to_polar_quadrant.sv
// ============================================================================
// cartesian_to_polar_quadrant: pipelined cartesian-to-polar converter
// Rounded magnitude, angle in 1/65536 turn and location class per point.
// ============================================================================
// Usage:
//   Coordinate channel: x_coord, y_coord with coord_valid / coord_stall.
//   Result channel: magnitude, angle_turns, location with polar_valid /
//   polar_stall. An item moves when valid is high and stall is low.
//   Throughput: one item per clock while the result channel does not hold
//   the pipeline frozen. The path from input to polar_valid is the
//   square-root digit chain of DEPTH = max(COORD_BITS, rotations used) steps
//   (one result bit per step), run in lockstep with the CORDIC rotations,
//   plus three input steps and two output registers.
//   Reset clears all valid bits; the block is empty and ready right after.
//   When the receiver stalls, the result waits in the output register and
//   the next one is caught by a skid register; only once that is full does
//   the whole pipeline freeze and coord_stall rise (it is a register).
//   Items are never dropped or duplicated.
// ============================================================================
module cartesian_to_polar_quadrant #(
    parameter int COORD_BITS    = c2pq_pkg::COORD_BITS_DEFAULT,
    parameter int CORDIC_STAGES = c2pq_pkg::CORDIC_STAGES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                coord_valid,
    output logic                                coord_stall,
    input  logic signed [COORD_BITS-1:0]        x_coord,
    input  logic signed [COORD_BITS-1:0]        y_coord,
    output logic                                polar_valid,
    input  logic                                polar_stall,
    output logic [c2pq_pkg::MAG_BITS-1:0]       magnitude,
    output logic [c2pq_pkg::ANGLE_BITS-1:0]     angle_turns,
    output logic [c2pq_pkg::LOC_BITS-1:0]       location
);

    localparam int ZW    = c2pq_pkg::ZW;
    localparam int VW    = COORD_BITS + c2pq_pkg::CORDIC_GUARD + 2;
    localparam int SW    = 2 * COORD_BITS;
    localparam int USED  = (CORDIC_STAGES < c2pq_pkg::ATAN_TABLE_LEN) ?
                           CORDIC_STAGES : c2pq_pkg::ATAN_TABLE_LEN;
    localparam int DEPTH = (COORD_BITS > USED) ? COORD_BITS : USED;

    // whole pipeline advances together; held only while the skid slot is full
    logic en;

    // core chain, index 0 is the front end output
    logic                 valid_w [0:DEPTH];
    c2pq_pkg::tag_t       tag_w   [0:DEPTH];
    logic signed [VW-1:0] vx_w    [0:DEPTH];
    logic signed [VW-1:0] vy_w    [0:DEPTH];
    logic signed [ZW-1:0] z_w     [0:DEPTH];
    logic [SW-1:0]        rem_w   [0:DEPTH];
    logic [SW-1:0]        root_w  [0:DEPTH];

    // finished item from the fold stage
    logic                              p_valid;
    logic [c2pq_pkg::MAG_BITS-1:0]     p_mag;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   p_angle;
    logic [c2pq_pkg::LOC_BITS-1:0]     p_loc;

    // output register and skid slot
    logic                              out_valid_reg, out_valid_next;
    logic [c2pq_pkg::MAG_BITS-1:0]     out_mag_reg, out_mag_next;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   out_angle_reg, out_angle_next;
    logic [c2pq_pkg::LOC_BITS-1:0]     out_loc_reg, out_loc_next;
    logic                              skid_valid_reg, skid_valid_next;
    logic [c2pq_pkg::MAG_BITS-1:0]     skid_mag_reg, skid_mag_next;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   skid_angle_reg, skid_angle_next;
    logic [c2pq_pkg::LOC_BITS-1:0]     skid_loc_reg, skid_loc_next;
    logic                              take;

    assign en          = !skid_valid_reg;
    assign coord_stall = skid_valid_reg;

    c2pq_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (coord_valid),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (valid_w[0]),
        .out_tag   (tag_w[0]),
        .out_vx    (vx_w[0]),
        .out_vy    (vy_w[0]),
        .out_z     (z_w[0]),
        .out_rem   (rem_w[0]),
        .out_root  (root_w[0])
    );

    // one rotation and one root digit per step, where that half is still in use
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_iter
        c2pq_iter #(
            .COORD_BITS    (COORD_BITS),
            .CORDIC_STAGES (CORDIC_STAGES),
            .IDX           (k)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[k]),
            .in_tag    (tag_w[k]),
            .in_vx     (vx_w[k]),
            .in_vy     (vy_w[k]),
            .in_z      (z_w[k]),
            .in_rem    (rem_w[k]),
            .in_root   (root_w[k]),
            .out_valid (valid_w[k+1]),
            .out_tag   (tag_w[k+1]),
            .out_vx    (vx_w[k+1]),
            .out_vy    (vy_w[k+1]),
            .out_z     (z_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_root  (root_w[k+1])
        );
    end

    c2pq_fold #(
        .COORD_BITS (COORD_BITS)
    ) u_fold (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (valid_w[DEPTH]),
        .in_tag        (tag_w[DEPTH]),
        .in_z          (z_w[DEPTH]),
        .in_rem        (rem_w[DEPTH]),
        .in_root       (root_w[DEPTH]),
        .out_valid     (p_valid),
        .out_magnitude (p_mag),
        .out_angle     (p_angle),
        .out_location  (p_loc)
    );

    // output register with skid slot; the fold item only moves when en is high
    always_comb
    begin
        take            = out_valid_reg && !polar_stall;
        out_valid_next  = out_valid_reg;
        out_mag_next    = out_mag_reg;
        out_angle_next  = out_angle_reg;
        out_loc_next    = out_loc_reg;
        skid_valid_next = skid_valid_reg;
        skid_mag_next   = skid_mag_reg;
        skid_angle_next = skid_angle_reg;
        skid_loc_next   = skid_loc_reg;

        if (skid_valid_reg)
        begin
            // pipeline frozen; drain the skid slot once the output is taken
            if (take)
            begin
                out_valid_next  = 1'b1;
                out_mag_next    = skid_mag_reg;
                out_angle_next  = skid_angle_reg;
                out_loc_next    = skid_loc_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = p_valid;
            out_mag_next   = p_mag;
            out_angle_next = p_angle;
            out_loc_next   = p_loc;
        end
        else if (p_valid)
        begin
            skid_valid_next = 1'b1;
            skid_mag_next   = p_mag;
            skid_angle_next = p_angle;
            skid_loc_next   = p_loc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_mag_reg    <= out_mag_next;
        out_angle_reg  <= out_angle_next;
        out_loc_reg    <= out_loc_next;
        skid_mag_reg   <= skid_mag_next;
        skid_angle_reg <= skid_angle_next;
        skid_loc_reg   <= skid_loc_next;
    end

    assign polar_valid = out_valid_reg;
    assign magnitude   = out_mag_reg;
    assign angle_turns = out_angle_reg;
    assign location    = out_loc_reg;

`ifndef SYNTHESIS
    // skid slot only fills behind a waiting output item
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with empty output register");

    // a full skid slot is empty in the cycle after the output is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !polar_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("skid slot did not drain into output register");

    // origin reports zero magnitude and zero angle
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && (location == c2pq_pkg::LOC_ORIGIN)
        |-> (magnitude == '0) && (angle_turns == c2pq_pkg::ANGLE_0))
        else $error("origin item with nonzero magnitude or angle");

    // points on the y axis sit at a quarter or three quarters of a turn
    a_y_axis_angle: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && (location == c2pq_pkg::LOC_Y_AXIS)
        |-> (angle_turns == c2pq_pkg::ANGLE_90) || (angle_turns == c2pq_pkg::ANGLE_270))
        else $error("y axis item with off-axis angle");
`endif

endmodule

// File: sv/c2pq_front.sv
// ============================================================================
// c2pq_front: input stages of the converter
// Absolute values and class, then squares, then sum of squares and CORDIC
// start vector. Three register stages, all advancing on en.
// ============================================================================
module c2pq_front #(
    parameter int COORD_BITS = c2pq_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [COORD_BITS-1:0]         x_coord,
    input  logic signed [COORD_BITS-1:0]         y_coord,
    output logic                                 out_valid,
    output c2pq_pkg::tag_t                       out_tag,
    output logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] out_vx,
    output logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] out_vy,
    output logic signed [c2pq_pkg::ZW-1:0]       out_z,
    output logic [2*COORD_BITS-1:0]              out_rem,
    output logic [2*COORD_BITS-1:0]              out_root
);

    localparam int GUARD = c2pq_pkg::CORDIC_GUARD;
    localparam int VW    = COORD_BITS + GUARD + 2;
    localparam int SW    = 2 * COORD_BITS;

    // stage 0: magnitudes and class
    logic                  v0_reg;
    logic [COORD_BITS-1:0] ax0_reg, ax0_next;
    logic [COORD_BITS-1:0] ay0_reg, ay0_next;
    c2pq_pkg::tag_t        tag0_reg, tag0_next;

    // stage 1: squares
    logic                  v1_reg;
    logic [COORD_BITS-1:0] ax1_reg, ay1_reg;
    logic [SW-1:0]         sqx1_reg, sqx1_next;
    logic [SW-1:0]         sqy1_reg, sqy1_next;
    c2pq_pkg::tag_t        tag1_reg;

    // stage 2: sum and start vector
    logic                  v2_reg;
    logic [SW-1:0]         rem2_reg, rem2_next;
    logic signed [VW-1:0]  vx2_reg, vx2_next;
    logic signed [VW-1:0]  vy2_reg, vy2_next;
    c2pq_pkg::tag_t        tag2_reg;

    logic x_zero, y_zero, x_neg, y_neg;

    always_comb
    begin
        x_zero = (x_coord == '0);
        y_zero = (y_coord == '0);
        x_neg  = x_coord[COORD_BITS-1];
        y_neg  = y_coord[COORD_BITS-1];

        // two's complement negate; the most negative input maps to 2^(N-1)
        ax0_next = x_neg ? $unsigned(-x_coord) : $unsigned(x_coord);
        ay0_next = y_neg ? $unsigned(-y_coord) : $unsigned(y_coord);

        tag0_next.neg = 1'b0;
        if (x_zero && y_zero) begin
            tag0_next.location = c2pq_pkg::LOC_ORIGIN;
        end
        else if (x_zero)
        begin
            tag0_next.location = c2pq_pkg::LOC_Y_AXIS;
            tag0_next.neg      = y_neg;
        end
        else if (y_zero)
        begin
            tag0_next.location = c2pq_pkg::LOC_X_AXIS;
            tag0_next.neg      = x_neg;
        end
        else if (!x_neg && !y_neg)
        begin
            tag0_next.location = c2pq_pkg::LOC_Q1;
        end
        else if (x_neg && !y_neg)
        begin
            tag0_next.location = c2pq_pkg::LOC_Q2;
        end
        else if (x_neg)
        begin
            tag0_next.location = c2pq_pkg::LOC_Q3;
        end
        else
        begin
            tag0_next.location = c2pq_pkg::LOC_Q4;
        end
    end

    always_comb
    begin
        sqx1_next = SW'(ax0_reg) * SW'(ax0_reg);
        sqy1_next = SW'(ay0_reg) * SW'(ay0_reg);
    end

    always_comb
    begin
        rem2_next = sqx1_reg + sqy1_reg;
        vx2_next  = $signed({2'b00, ax1_reg, {GUARD{1'b0}}});
        vy2_next  = $signed({2'b00, ay1_reg, {GUARD{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax0_reg  <= ax0_next;
            ay0_reg  <= ay0_next;
            tag0_reg <= tag0_next;

            ax1_reg  <= ax0_reg;
            ay1_reg  <= ay0_reg;
            sqx1_reg <= sqx1_next;
            sqy1_reg <= sqy1_next;
            tag1_reg <= tag0_reg;

            rem2_reg <= rem2_next;
            vx2_reg  <= vx2_next;
            vy2_reg  <= vy2_next;
            tag2_reg <= tag1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_tag   = tag2_reg;
    assign out_vx    = vx2_reg;
    assign out_vy    = vy2_reg;
    assign out_z     = '0;
    assign out_rem   = rem2_reg;
    assign out_root  = '0;

endmodule

// File: sv/c2pq_iter.sv
// ============================================================================
// c2pq_iter: one pipeline step of the converter core
// One CORDIC vectoring rotation and one square-root digit, both registered.
// Steps past the rotation count or the root width pass that half through.
// ============================================================================
module c2pq_iter #(
    parameter int COORD_BITS    = c2pq_pkg::COORD_BITS_DEFAULT,
    parameter int CORDIC_STAGES = c2pq_pkg::CORDIC_STAGES_DEFAULT,
    parameter int IDX           = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  c2pq_pkg::tag_t                       in_tag,
    input  logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] in_vx,
    input  logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] in_vy,
    input  logic signed [c2pq_pkg::ZW-1:0]       in_z,
    input  logic [2*COORD_BITS-1:0]              in_rem,
    input  logic [2*COORD_BITS-1:0]              in_root,
    output logic                                 out_valid,
    output c2pq_pkg::tag_t                       out_tag,
    output logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] out_vx,
    output logic signed [COORD_BITS+c2pq_pkg::CORDIC_GUARD+1:0] out_vy,
    output logic signed [c2pq_pkg::ZW-1:0]       out_z,
    output logic [2*COORD_BITS-1:0]              out_rem,
    output logic [2*COORD_BITS-1:0]              out_root
);

    localparam int  ZW        = c2pq_pkg::ZW;
    localparam int  VW        = COORD_BITS + c2pq_pkg::CORDIC_GUARD + 2;
    localparam int  SW        = 2 * COORD_BITS;
    localparam int  USED      = (CORDIC_STAGES < c2pq_pkg::ATAN_TABLE_LEN) ?
                                CORDIC_STAGES : c2pq_pkg::ATAN_TABLE_LEN;
    localparam bit  DO_CORDIC = (IDX < USED);
    localparam bit  DO_SQRT   = (IDX < COORD_BITS);
    localparam int  BIT_POS   = DO_SQRT ? 2 * (COORD_BITS - 1 - IDX) : 0;
    localparam logic [SW-1:0] BIT_VAL = DO_SQRT ? (SW'(1) << BIT_POS) : '0;
    localparam logic signed [ZW-1:0] ATAN = c2pq_pkg::atan_step(IDX);

    logic                 valid_reg;
    c2pq_pkg::tag_t       tag_reg;
    logic signed [VW-1:0] vx_reg, vx_next;
    logic signed [VW-1:0] vy_reg, vy_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]        root_reg, root_next;

    logic signed [VW-1:0] dx, dy;
    logic [SW-1:0]        trial;

    // CORDIC: drive y toward zero, accumulate the angle turned
    always_comb
    begin
        dx = in_vy >>> IDX;
        dy = in_vx >>> IDX;
        vx_next = in_vx;
        vy_next = in_vy;
        z_next  = in_z;
        if (DO_CORDIC)
        begin
            if (!in_vy[VW-1])
            begin
                vx_next = in_vx + dx;
                vy_next = in_vy - dy;
                z_next  = in_z + ATAN;
            end
            else
            begin
                vx_next = in_vx - dx;
                vy_next = in_vy + dy;
                z_next  = in_z - ATAN;
            end
        end
    end

    // restoring square root, one result bit
    always_comb
    begin
        trial     = in_root + BIT_VAL;
        rem_next  = in_rem;
        root_next = in_root;
        if (DO_SQRT)
        begin
            if (in_rem >= trial)
            begin
                rem_next  = in_rem - trial;
                root_next = (in_root >> 1) + BIT_VAL;
            end
            else
            begin
                root_next = in_root >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg  <= in_tag;
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            z_reg    <= z_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_vx    = vx_reg;
    assign out_vy    = vy_reg;
    assign out_z     = z_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// File: sv/c2pq_fold.sv
// ============================================================================
// c2pq_fold: final stage of the converter
// Rounds the root and the CORDIC angle, folds the angle into its quadrant
// and registers the finished item.
// ============================================================================
module c2pq_fold #(
    parameter int COORD_BITS = c2pq_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  c2pq_pkg::tag_t                        in_tag,
    input  logic signed [c2pq_pkg::ZW-1:0]        in_z,
    input  logic [2*COORD_BITS-1:0]               in_rem,
    input  logic [2*COORD_BITS-1:0]               in_root,
    output logic                                  out_valid,
    output logic [c2pq_pkg::MAG_BITS-1:0]         out_magnitude,
    output logic [c2pq_pkg::ANGLE_BITS-1:0]       out_angle,
    output logic [c2pq_pkg::LOC_BITS-1:0]         out_location
);

    localparam int ZW = c2pq_pkg::ZW;
    localparam int SW = 2 * COORD_BITS;

    logic                              valid_reg;
    logic [c2pq_pkg::MAG_BITS-1:0]     mag_reg, mag_next;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   angle_reg, angle_next;
    logic [c2pq_pkg::LOC_BITS-1:0]     loc_reg;

    logic [SW-1:0]                     mag_wide;
    logic signed [ZW-1:0]              z_pos;
    logic [ZW-1:0]                     z_round;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   z_turn;
    logic [c2pq_pkg::ANGLE_BITS-1:0]   a;

    always_comb
    begin
        // round to nearest: remainder above root means the next integer is closer
        mag_wide = in_root + ((in_rem > in_root) ? SW'(1) : SW'(0));
        if (mag_wide > SW'(c2pq_pkg::MAG_MAX))
        begin
            mag_next = c2pq_pkg::MAG_MAX;
        end
        else
        begin
            mag_next = mag_wide[c2pq_pkg::MAG_BITS-1:0];
        end

        z_pos   = in_z[ZW-1] ? '0 : in_z;
        z_round = $unsigned(z_pos) + ZW'(32768);
        z_turn  = z_round[ZW-1:ZW-c2pq_pkg::ANGLE_BITS];
        a       = (z_turn > c2pq_pkg::ANGLE_90) ? c2pq_pkg::ANGLE_90 : z_turn;

        case (in_tag.location)
            c2pq_pkg::LOC_ORIGIN: angle_next = c2pq_pkg::ANGLE_0;
            c2pq_pkg::LOC_Y_AXIS: angle_next = in_tag.neg ? c2pq_pkg::ANGLE_270
                                                          : c2pq_pkg::ANGLE_90;
            c2pq_pkg::LOC_X_AXIS: angle_next = in_tag.neg ? c2pq_pkg::ANGLE_180
                                                          : c2pq_pkg::ANGLE_0;
            c2pq_pkg::LOC_Q1:     angle_next = a;
            c2pq_pkg::LOC_Q2:     angle_next = c2pq_pkg::ANGLE_180 - a;
            c2pq_pkg::LOC_Q3:     angle_next = c2pq_pkg::ANGLE_180 + a;
            c2pq_pkg::LOC_Q4:     angle_next = c2pq_pkg::ANGLE_0 - a;
            default:              angle_next = c2pq_pkg::ANGLE_0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_next;
            angle_reg <= angle_next;
            loc_reg   <= in_tag.location;
        end
    end

    assign out_valid     = valid_reg;
    assign out_magnitude = mag_reg;
    assign out_angle     = angle_reg;
    assign out_location  = loc_reg;

endmodule
